[hw/rtl/rws_pkg.sv]
// Shared types and constants of the roulette wheel selector.
// Holds opcode and status codes and the fixed field widths of the stream ports.
// No dependencies.
package rws_pkg;

    localparam int FIELD_W    = 16;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 16;
    localparam int IDX_OUT_W  = 10;

    typedef logic [1:0]           op_t;
    typedef logic [1:0]           stat_t;
    typedef logic [IDX_OUT_W-1:0] idx_out_t;

    localparam op_t OP_LOAD   = 2'd0;
    localparam op_t OP_NEW    = 2'd1;
    localparam op_t OP_SELECT = 2'd2;

    localparam stat_t STAT_LOADED   = 2'd0;
    localparam stat_t STAT_SELECTED = 2'd1;
    localparam stat_t STAT_FULL     = 2'd2;
    localparam stat_t STAT_EMPTY    = 2'd3;

endpackage

[hw/rtl/roulette_wheel_selector.sv]
// Roulette wheel selector top level: load and select control, entry count,
// running total and result register. Depends on rws_pkg, rws_sum_mem,
// rws_thresh and rws_search.
//
// Usage: each input transfer carries an opcode in s_tuser and a fitness and a
// draw in s_tdata. A load appends the fitness and stores the new running sum
// in the sum memory; a new-set load first empties the set. A select finds the
// smallest entry whose cumulative sum reaches draw * total / 2^DRAW_BITS. Every
// input transfer yields exactly one result transfer with the entry index in
// m_tdata and a status code in m_tuser.
// Loads and refused operations finish at acceptance and their result is
// registered for output. No new input is taken while a select runs: the
// threshold multiply comes first, then the search makes up to
// ceil(log2(entry count)) memory probes (10 for a full set of 1024), one
// probe per cycle on the memory read port, and then its result is registered
// for output. Input is taken while a result waits in the output register; if
// the receiver stalls, one more result is parked and input stops.
// Reset empties the set and drops any result in flight; memory contents are
// not cleared.
module roulette_wheel_selector #(
    parameter int MAX_ENTRIES = 1024,
    parameter int FIT_BITS    = 16,
    parameter int DRAW_BITS   = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rws_pkg::S_DATA_W-1:0] s_tdata,  // fitness[15:0], draw[31:16]
    input  logic [1:0]                   s_tuser,  // opcode[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rws_pkg::M_DATA_W-1:0] m_tdata,  // selected_index[9:0], zero[15:10]
    output logic [1:0]                   m_tuser   // status[1:0]
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int FW    = (FIT_BITS < rws_pkg::FIELD_W) ? FIT_BITS : rws_pkg::FIELD_W;
    localparam int SUM_W = FW + IDX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_THR  = 2'd1;
    localparam logic [1:0] ST_SRCH = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    tot_reg, tot_next;
    logic                m_tvalid_reg, m_tvalid_next;
    rws_pkg::idx_out_t   m_idx_reg;
    rws_pkg::stat_t      m_stat_reg;
    rws_pkg::idx_out_t   hold_idx_reg;
    rws_pkg::stat_t      hold_stat_reg;

    rws_pkg::op_t        op;
    logic                acc;
    logic                out_free;
    logic [CNT_W-1:0]    base_cnt;
    logic [SUM_W-1:0]    base_tot;
    logic [SUM_W-1:0]    new_tot;
    logic                full;
    logic                sel_ok;
    logic                mem_we;
    logic                thr_start;
    logic                res_valid;
    rws_pkg::idx_out_t   res_idx;
    rws_pkg::stat_t      res_stat;

    logic                thr_done;
    logic [SUM_W-1:0]    thr_val;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [SUM_W-1:0]    rd_data;
    logic                srch_done;
    logic [IDX_W-1:0]    srch_idx;

    assign op       = s_tuser;
    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign base_cnt = (op == rws_pkg::OP_NEW) ? '0 : cnt_reg;
    assign base_tot = (op == rws_pkg::OP_NEW) ? '0 : tot_reg;
    assign full     = (base_cnt == CNT_W'(MAX_ENTRIES));
    assign new_tot  = base_tot + SUM_W'(s_tdata[FW-1:0]);
    assign sel_ok   = (cnt_reg != '0) && (tot_reg != '0);

    assign mem_we    = acc && (op == rws_pkg::OP_LOAD || op == rws_pkg::OP_NEW) && !full;
    assign thr_start = acc && (op == rws_pkg::OP_SELECT) && sel_ok;

    always_comb begin
        res_valid  = 1'b0;
        res_idx    = '0;
        res_stat   = rws_pkg::STAT_EMPTY;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    unique case (op)
                        rws_pkg::OP_LOAD, rws_pkg::OP_NEW: begin
                            res_valid = 1'b1;
                            if (full) begin
                                res_stat = rws_pkg::STAT_FULL;
                            end else begin
                                res_stat = rws_pkg::STAT_LOADED;
                                res_idx  = rws_pkg::idx_out_t'(base_cnt);
                            end
                        end
                        rws_pkg::OP_SELECT: begin
                            if (sel_ok) begin
                                state_next = ST_THR;
                            end else begin
                                res_valid = 1'b1;
                            end
                        end
                        default: begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_THR: begin
                if (thr_done) begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (srch_done) begin
                    res_valid = 1'b1;
                    res_stat  = rws_pkg::STAT_SELECTED;
                    res_idx   = rws_pkg::idx_out_t'(srch_idx);
                end
            end
            ST_HOLD: begin
                res_valid = 1'b1;
                res_idx   = hold_idx_reg;
                res_stat  = hold_stat_reg;
            end
        endcase
        if (res_valid) begin
            state_next = out_free ? ST_IDLE : ST_HOLD;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        tot_next = tot_reg;
        if (mem_we) begin
            cnt_next = base_cnt + CNT_W'(1);
            tot_next = new_tot;
        end
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (res_valid && out_free) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            tot_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            tot_reg      <= tot_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_idx_reg  <= res_idx;
            m_stat_reg <= res_stat;
        end
        if (res_valid) begin
            hold_idx_reg  <= res_idx;
            hold_stat_reg <= res_stat;
        end
    end

    rws_sum_mem #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (SUM_W)
    ) u_mem (
        .aclk    (aclk),
        .we_i    (mem_we),
        .waddr_i (base_cnt[IDX_W-1:0]),
        .wdata_i (new_tot),
        .re_i    (rd_en),
        .raddr_i (rd_addr),
        .rdata_o (rd_data)
    );

    rws_thresh #(
        .SUM_W     (SUM_W),
        .DRAW_BITS (DRAW_BITS)
    ) u_thresh (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (thr_start),
        .draw_i  (s_tdata[rws_pkg::S_DATA_W-1:rws_pkg::FIELD_W]),
        .total_i (tot_reg),
        .done_o  (thr_done),
        .thr_o   (thr_val)
    );

    rws_search #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_i   (thr_done),
        .count_i   (cnt_reg),
        .thr_i     (thr_val),
        .rdata_i   (rd_data),
        .rd_en_o   (rd_en),
        .rd_addr_o (rd_addr),
        .done_o    (srch_done),
        .index_o   (srch_idx)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(rws_pkg::M_DATA_W - rws_pkg::IDX_OUT_W){1'b0}}, m_idx_reg};
    assign m_tuser  = m_stat_reg;

    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (tot_reg == '0))
        else $error("running total is nonzero while the set is empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds capacity");

    a_thr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        thr_done |-> (state_reg == ST_THR))
        else $error("threshold finished outside the threshold phase");

    a_srch_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        srch_done |-> (CNT_W'(srch_idx) < cnt_reg))
        else $error("search returned an index beyond the set");

endmodule

[hw/rtl/rws_sum_mem.sv]
// Cumulative sum store: one write port and one read port with registered read data.
// No dependencies.
module rws_sum_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 26
) (
    input  logic              aclk,
    input  logic              we_i,
    input  logic [ADDR_W-1:0] waddr_i,
    input  logic [DATA_W-1:0] wdata_i,
    input  logic              re_i,
    input  logic [ADDR_W-1:0] raddr_i,
    output logic [DATA_W-1:0] rdata_o
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem[waddr_i] <= wdata_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (re_i) begin
            rdata_reg <= mem[raddr_i];
        end
    end

    assign rdata_o = rdata_reg;

endmodule

[hw/rtl/rws_thresh.sv]
// Search threshold unit: ceil(draw * total / 2^DRAW_BITS) from two partial products,
// a merge and a rounding add, each registered in turn. Depends on rws_pkg.
module rws_thresh #(
    parameter int SUM_W     = 26,
    parameter int DRAW_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start_i,
    input  logic [rws_pkg::FIELD_W-1:0] draw_i,
    input  logic [SUM_W-1:0]            total_i,
    output logic                        done_o,
    output logic [SUM_W-1:0]            thr_o
);

    localparam int DW   = (DRAW_BITS < rws_pkg::FIELD_W) ? DRAW_BITS : rws_pkg::FIELD_W;
    localparam int LO_W = (SUM_W + 1) / 2;
    localparam int HI_W = SUM_W - LO_W;
    localparam int PW   = SUM_W + DRAW_BITS;
    localparam logic [PW:0] RND = (PW+1)'({DRAW_BITS{1'b1}});

    logic [DW-1:0]      d_reg;
    logic [SUM_W-1:0]   t_reg;
    logic [DW+LO_W-1:0] plo_reg;
    logic [DW+HI_W-1:0] phi_reg;
    logic [PW-1:0]      psum_reg;
    logic [SUM_W-1:0]   thr_reg;
    logic [4:0]         v_reg;
    logic [4:0]         v_next;
    logic [PW:0]        rsum;

    assign v_next = {v_reg[3:0], start_i};
    assign rsum   = {1'b0, psum_reg} + RND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            d_reg <= draw_i[DW-1:0];
            t_reg <= total_i;
        end
        if (v_reg[0]) begin
            plo_reg <= (DW+LO_W)'(d_reg) * (DW+LO_W)'(t_reg[LO_W-1:0]);
        end
        if (v_reg[1]) begin
            phi_reg <= (DW+HI_W)'(d_reg) * (DW+HI_W)'(t_reg[SUM_W-1:LO_W]);
        end
        if (v_reg[2]) begin
            psum_reg <= PW'(plo_reg) + (PW'(phi_reg) << LO_W);
        end
        if (v_reg[3]) begin
            thr_reg <= rsum[PW-1:DRAW_BITS];
        end
    end

    assign done_o = v_reg[4];
    assign thr_o  = thr_reg;

endmodule

[hw/rtl/rws_search.sv]
// Binary search sequencer over the cumulative sum store, one probe per cycle.
// The compare of the returned sum steers the next read address. No dependencies.
module rws_search #(
    parameter int IDX_W = 10,
    parameter int CNT_W = 11,
    parameter int SUM_W = 26
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start_i,
    input  logic [CNT_W-1:0] count_i,
    input  logic [SUM_W-1:0] thr_i,
    input  logic [SUM_W-1:0] rdata_i,
    output logic             rd_en_o,
    output logic [IDX_W-1:0] rd_addr_o,
    output logic             done_o,
    output logic [IDX_W-1:0] index_o
);

    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;
    logic             go;
    logic [CNT_W-1:0] last;

    assign last = count_i - CNT_W'(1);

    always_comb begin
        go        = 1'b0;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        pend_next = 1'b0;
        done_next = 1'b0;
        idx_next  = idx_reg;
        priority if (start_i) begin
            go      = 1'b1;
            lo_next = '0;
            hi_next = last[IDX_W-1:0];
        end else if (pend_reg) begin
            go = 1'b1;
            if (rdata_i >= thr_i) begin
                hi_next = mid_reg;
            end else begin
                lo_next = mid_reg + IDX_W'(1);
            end
        end else begin
            go = 1'b0;
        end
        mid_next = lo_next + ((hi_next - lo_next) >> 1);
        if (go) begin
            if (lo_next < hi_next) begin
                pend_next = 1'b1;
            end else begin
                done_next = 1'b1;
                idx_next  = lo_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        idx_reg <= idx_next;
    end

    assign rd_en_o   = pend_next;
    assign rd_addr_o = mid_next;
    assign done_o    = done_reg;
    assign index_o   = idx_reg;

endmodule

[verif/roulette_wheel_selector_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the roulette wheel selector: loads, new sets, selects
// and unused opcodes are driven as stream transfers, predicted in place and checked
// per result. Depends on rws_pkg and the roulette_wheel_selector RTL.
module roulette_wheel_selector_tb;

    localparam int           NUM_ENTRIES = 1024;
    localparam rws_pkg::op_t OP_UNUSED   = 2'd3;
    localparam int           CYCLE_LIMIT = 500000;
    localparam int           DRAIN_WAIT  = 40;
    localparam int           HOLD_CYCLES = 400;

    typedef struct {
        rws_pkg::op_t                opcode;
        logic [rws_pkg::FIELD_W-1:0] fitness;
        logic [rws_pkg::FIELD_W-1:0] draw;
    } wheel_item_t;

    typedef struct {
        rws_pkg::idx_out_t idx;
        rws_pkg::stat_t    st;
    } wheel_result_t;

    logic                         aclk;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [rws_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [1:0]                   s_tuser  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [rws_pkg::M_DATA_W-1:0] m_tdata;
    logic [1:0]                   m_tuser;

    wheel_item_t   pending_items[$];
    wheel_result_t expected_picks[$];
    logic [25:0]   cum_sums[NUM_ENTRIES];
    logic [25:0]   wheel_total = '0;
    int            set_size = 0;
    int            accepted_cnt = 0;
    int            phase_len = 1 << 30;
    int            error_cnt = 0;
    int            cycle_cnt = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;

    roulette_wheel_selector u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic wheel_result_t wheel_predict(rws_pkg::op_t op,
                                                    logic [rws_pkg::FIELD_W-1:0] fit,
                                                    logic [rws_pkg::FIELD_W-1:0] drw);
        wheel_result_t r;
        logic [41:0]   target;
        int            lo;
        int            hi;
        int            mid;
        r.idx = '0;
        r.st  = rws_pkg::STAT_EMPTY;
        if (op == rws_pkg::OP_LOAD || op == rws_pkg::OP_NEW) begin
            if (op == rws_pkg::OP_NEW) begin
                set_size    = 0;
                wheel_total = '0;
            end
            if (set_size >= NUM_ENTRIES) begin
                r.st = rws_pkg::STAT_FULL;
            end else begin
                wheel_total        = wheel_total + fit;
                cum_sums[set_size] = wheel_total;
                r.idx              = rws_pkg::idx_out_t'(set_size);
                r.st               = rws_pkg::STAT_LOADED;
                set_size++;
            end
        end else if (op == rws_pkg::OP_SELECT && set_size != 0 && wheel_total != 0) begin
            // Smallest entry whose scaled cumulative sum reaches draw times total.
            target = 42'(drw) * 42'(wheel_total);
            lo     = 0;
            hi     = set_size - 1;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if ({cum_sums[mid], 16'h0000} >= target) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            r.idx = rws_pkg::idx_out_t'(lo);
            r.st  = rws_pkg::STAT_SELECTED;
        end
        return r;
    endfunction

    function automatic int sender_idle_pct();
        if (accepted_cnt < phase_len) return 23;
        if (accepted_cnt < 2 * phase_len) return 68;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted_cnt < phase_len) return 68;
        if (accepted_cnt < 2 * phase_len) return 23;
        return 0;
    endfunction

    function automatic logic [rws_pkg::FIELD_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return rws_pkg::FIELD_W'($urandom);
        endcase
    endfunction

    task automatic add_item(rws_pkg::op_t op, logic [rws_pkg::FIELD_W-1:0] fit,
                            logic [rws_pkg::FIELD_W-1:0] drw);
        wheel_item_t item;
        item.opcode  = op;
        item.fitness = fit;
        item.draw    = drw;
        pending_items.insert(pending_items.size(), item);
    endtask

    task automatic add_load(rws_pkg::op_t op);
        add_item(op, pick_value(), rws_pkg::FIELD_W'($urandom));
    endtask

    task automatic add_select();
        add_item(rws_pkg::OP_SELECT, rws_pkg::FIELD_W'($urandom), pick_value());
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                wheel_item_t item;
                item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {item.draw, item.fitness};
                s_tuser  <= item.opcode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            // One long stall once the idle-free phase begins, so the input backs up.
            if (!hold_done && accepted_cnt >= 2 * phase_len) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    always @(posedge aclk) begin
        wheel_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_picks.insert(expected_picks.size(),
                                      wheel_predict(s_tuser, s_tdata[15:0], s_tdata[31:16]));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_picks.size() == 0) begin
                    $display("%0t: unexpected result transfer index %0d status %0d",
                             $time, m_tdata[rws_pkg::IDX_OUT_W-1:0], m_tuser);
                    error_cnt++;
                end else begin
                    want = expected_picks.pop_front();
                    if (m_tdata[rws_pkg::IDX_OUT_W-1:0] != want.idx) begin
                        $display("%0t: index mismatch expected %0d actual %0d",
                                 $time, want.idx, m_tdata[rws_pkg::IDX_OUT_W-1:0]);
                        error_cnt++;
                    end
                    if (m_tuser != want.st) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.st, m_tuser);
                        error_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("roulette_wheel_selector test failed");
            $finish;
        end
    end

    initial begin
        int  target_cnt;
        int  set_len;
        int  extra;
        // Empty set, unused opcode, then zero totals before any nonzero weight is loaded.
        add_item(rws_pkg::OP_SELECT, 16'hFFFF, 16'h0000);
        add_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        add_item(rws_pkg::OP_NEW, 16'h0000, 16'hFFFF);
        add_item(rws_pkg::OP_SELECT, 16'h0000, 16'h0000);
        add_item(rws_pkg::OP_LOAD, 16'h0000, 16'h0000);
        add_item(rws_pkg::OP_SELECT, 16'h0000, 16'hFFFF);
        // A zero draw still picks a zero-weight first entry.
        add_item(rws_pkg::OP_LOAD, 16'hFFFF, 16'h0000);
        add_item(rws_pkg::OP_SELECT, 16'h0000, 16'h0000);
        add_item(rws_pkg::OP_SELECT, 16'hFFFF, 16'hFFFF);
        add_item(rws_pkg::OP_SELECT, 16'h1234, 16'h0001);
        add_item(rws_pkg::OP_LOAD, 16'h0001, 16'hAAAA);
        add_item(rws_pkg::OP_LOAD, 16'h8000, 16'h5555);
        add_item(rws_pkg::OP_SELECT, 16'h0000, 16'h8000);
        add_item(rws_pkg::OP_SELECT, 16'h0000, 16'h7FFF);
        add_item(OP_UNUSED, 16'h5555, 16'hAAAA);
        add_item(rws_pkg::OP_NEW, 16'hFFFF, 16'h0000);
        add_item(rws_pkg::OP_SELECT, 16'h0000, 16'h0000);
        add_item(rws_pkg::OP_SELECT, 16'h0000, 16'hFFFF);
        add_item(rws_pkg::OP_LOAD, 16'h5555, 16'h0000);
        add_item(rws_pkg::OP_LOAD, 16'hAAAA, 16'h0000);
        add_item(rws_pkg::OP_SELECT, 16'hAAAA, 16'h5555);
        add_item(rws_pkg::OP_SELECT, 16'h5555, 16'hAAAA);

        target_cnt = 550;
        while (pending_items.size() < target_cnt) begin
            if ($urandom_range(99) < 80) begin
                set_len = ($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 12);
                if (set_len > target_cnt - pending_items.size()) begin
                    set_len = target_cnt - pending_items.size();
                end
                add_load(rws_pkg::OP_NEW);
                for (int i = 1; i < set_len; i++) begin
                    add_load(rws_pkg::OP_LOAD);
                    if ($urandom_range(3) == 0) add_select();
                end
                repeat ($urandom_range(1, 8)) add_select();
            end else begin
                extra = $urandom_range(1, 4);
                repeat (extra) add_item(rws_pkg::op_t'($urandom_range(3)),
                                        rws_pkg::FIELD_W'($urandom),
                                        rws_pkg::FIELD_W'($urandom));
            end
        end
        phase_len = pending_items.size() / 3;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid || expected_picks.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_cnt == 0 && expected_picks.size() == 0) begin
            $display("roulette_wheel_selector test passed");
        end else begin
            $display("roulette_wheel_selector test failed");
        end
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/rws_pkg.sv
hw/rtl/rws_sum_mem.sv
hw/rtl/rws_thresh.sv
hw/rtl/rws_search.sv
hw/rtl/roulette_wheel_selector.sv
verif/roulette_wheel_selector_tb.sv
